>>> hdl/request_latency_metrics_unit_defines.svh
// ----------------------------------------------------------------------------
// request latency metrics unit: assertion macros
// shared checking shorthands for the block's concurrent assertions
// ----------------------------------------------------------------------------
`ifndef REQUEST_LATENCY_METRICS_UNIT_DEFINES_SVH
`define REQUEST_LATENCY_METRICS_UNIT_DEFINES_SVH

// same-cycle implication
`define RLM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rlm: assertion failed");

// next-cycle implication
`define RLM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rlm: assertion failed");

`endif

>>> hdl/rlm_pkg.sv
// ----------------------------------------------------------------------------
// rlm_pkg
// shared types and constants of the request latency metrics unit
// ----------------------------------------------------------------------------
package rlm_pkg;

  localparam int unsigned BUCKETS_PER_TIER_DEF = 10;
  localparam int unsigned COUNTER_BITS_DEF     = 32;

  localparam int unsigned NUM_WINDOWS = 5;
  localparam int unsigned NUM_ROLLING = 3;
  localparam int unsigned NUM_KINDS   = 3;

  localparam int unsigned SHORT_MS = 10;
  localparam int unsigned MID_MS   = 100;
  localparam int unsigned LONG_MS  = 1000;

  localparam int unsigned ACT_W    = 3;
  localparam int unsigned LAT_W    = 32;
  localparam int unsigned SEL_W    = 6;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned PERIOD_W = 20;
  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned EXT_W    = 64;

  localparam int unsigned CMD_FIFO_DEPTH = 4;
  localparam int unsigned OUT_FIFO_DEPTH = 2;

  localparam logic [PERIOD_W-1:0] MINUTE_PERIOD_RST = 20'd60;
  localparam logic [PERIOD_W-1:0] HOUR_PERIOD_RST   = 20'd3600;
  localparam logic [PERIOD_W-1:0] DAY_PERIOD_RST    = 20'd86400;

  // register indexes on the configuration port
  localparam logic [1:0] REG_MINUTE = 2'd0;
  localparam logic [1:0] REG_HOUR   = 2'd1;
  localparam logic [1:0] REG_DAY    = 2'd2;

  typedef enum logic [ACT_W-1:0] {
    ACT_REQ_BEGIN  = 3'd0,
    ACT_REQ_END    = 3'd1,
    ACT_SEC_TICK   = 3'd2,
    ACT_CONN_OPEN  = 3'd3,
    ACT_CONN_CLOSE = 3'd4,
    ACT_READ       = 3'd5
  } action_e;

  typedef struct packed {
    action_e          act;
    logic             success;
    logic [SEL_W-1:0] sel;
  } item_ctl_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] minute;
    logic [PERIOD_W-1:0] hour;
    logic [PERIOD_W-1:0] day;
  } periods_t;

endpackage

>>> hdl/rlm_fifo.sv
// ----------------------------------------------------------------------------
// rlm_fifo
// small register-based first-in first-out queue
// ----------------------------------------------------------------------------
module rlm_fifo import rlm_pkg::*; #(
  parameter int unsigned WIDTH = DATA_W,
  parameter int unsigned DEPTH = CMD_FIFO_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

>>> hdl/rlm_front.sv
// ----------------------------------------------------------------------------
// rlm_front
// decodes the event code and files an ending latency into its bucket
// ----------------------------------------------------------------------------
module rlm_front import rlm_pkg::*; #(
  parameter int unsigned BUCKETS_PER_TIER = BUCKETS_PER_TIER_DEF,
  localparam int unsigned BIDX_W = $clog2(3 * BUCKETS_PER_TIER)
) (
  input  logic [ACT_W-1:0]  action_i,
  input  logic [LAT_W-1:0]  latency_ms_i,
  input  logic              success_flag_i,
  input  logic [SEL_W-1:0]  read_select_i,
  output logic              vld_o,
  output item_ctl_t         ctl_o,
  output logic [BIDX_W-1:0] bucket_o
);

  logic [BUCKETS_PER_TIER-2:0] ge_short, ge_mid, ge_long;

  // thermometer of bucket boundaries in each tier
  always_comb begin
    for (int k = 1; k < BUCKETS_PER_TIER; k++) begin
      ge_short[k-1] = latency_ms_i >= LAT_W'(SHORT_MS * k);
      ge_mid[k-1]   = latency_ms_i >= LAT_W'(MID_MS * k);
      ge_long[k-1]  = latency_ms_i >= LAT_W'(LONG_MS * k);
    end
  end

  // the long tier saturates by construction of its thermometer
  always_comb begin
    priority if (latency_ms_i < LAT_W'(SHORT_MS * BUCKETS_PER_TIER)) begin
      bucket_o = BIDX_W'($countones(ge_short));
    end else if (latency_ms_i < LAT_W'(MID_MS * BUCKETS_PER_TIER)) begin
      bucket_o = BIDX_W'(BUCKETS_PER_TIER) + BIDX_W'($countones(ge_mid));
    end else begin
      bucket_o = BIDX_W'(2 * BUCKETS_PER_TIER) + BIDX_W'($countones(ge_long));
    end
  end

  always_comb begin
    unique case (action_i)
      ACT_REQ_BEGIN, ACT_REQ_END, ACT_SEC_TICK,
      ACT_CONN_OPEN, ACT_CONN_CLOSE, ACT_READ: vld_o = 1'b1;
      default:                                 vld_o = 1'b0;
    endcase
  end

  assign ctl_o.act     = action_e'(action_i);
  assign ctl_o.success = success_flag_i;
  assign ctl_o.sel     = read_select_i;

endmodule

>>> hdl/rlm_back.sv
// ----------------------------------------------------------------------------
// rlm_back
// applies queued events to the histogram and window counters, serves reads
// ----------------------------------------------------------------------------
module rlm_back import rlm_pkg::*; #(
  parameter int unsigned BUCKETS_PER_TIER = BUCKETS_PER_TIER_DEF,
  parameter int unsigned COUNTER_BITS     = COUNTER_BITS_DEF,
  localparam int unsigned BIDX_W = $clog2(3 * BUCKETS_PER_TIER)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  periods_t          periods_i,
  input  logic              q_empty_i,
  input  item_ctl_t         q_ctl_i,
  input  logic [BIDX_W-1:0] q_bucket_i,
  output logic              q_pop_o,
  input  logic              out_full_i,
  output logic              out_push_o,
  output logic [DATA_W-1:0] out_data_o
);

  localparam int unsigned NB = 3 * BUCKETS_PER_TIER;
  localparam int unsigned CW = COUNTER_BITS;
  localparam int unsigned XS = SEL_W + 1;

  logic              advance, fire;
  logic              b2_vld_q;
  item_ctl_t         b2_ctl_q;
  logic [BIDX_W-1:0] b2_bucket_q;

  // histogram memory, entries not yet written read as zero
  logic [CW-1:0]     hist_mem [NB];
  logic [NB-1:0]     hist_vld_q;
  logic [CW-1:0]     rda_q, rdb_q, byp_data_q;
  logic              rda_vld_q, rdb_vld_q, byp_a_q, byp_b_q;
  logic [BIDX_W-1:0] rb_addr;
  logic              hist_wr;
  logic [CW-1:0]     hist_cur, hist_sel, hist_wdata;

  logic [CW-1:0] tot_q [NUM_WINDOWS], tot_d [NUM_WINDOWS];
  logic [CW-1:0] suc_q [NUM_WINDOWS], suc_d [NUM_WINDOWS];
  logic [CW-1:0] pk_q  [NUM_WINDOWS], pk_d  [NUM_WINDOWS];
  logic [CW-1:0] btot_q [NUM_WINDOWS], btot_d [NUM_WINDOWS];
  logic [CW-1:0] bsuc_q [NUM_WINDOWS], bsuc_d [NUM_WINDOWS];
  logic [CW-1:0] bpk_q  [NUM_WINDOWS], bpk_d  [NUM_WINDOWS];
  logic [CW-1:0] in_flight_q, in_flight_d;
  logic [CW-1:0] conns_q, conns_d;
  logic [PERIOD_W-1:0] ticks_q [NUM_ROLLING], ticks_d [NUM_ROLLING];
  logic [PERIOD_W-1:0] tick_nxt [NUM_ROLLING];
  logic [PERIOD_W-1:0] period [NUM_ROLLING];
  logic [NUM_WINDOWS-1:0] roll;

  logic [XS-1:0]    sel_x;
  logic             win_hit;
  logic [CW-1:0]    win_live, win_bak, rd_val;
  logic [EXT_W-1:0] rd_ext;

  // a read waiting on a full result queue holds the whole back end
  assign advance = !(b2_vld_q && (b2_ctl_q.act == ACT_READ) && out_full_i);
  assign q_pop_o = advance && !q_empty_i;
  assign fire    = advance && b2_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b2_vld_q <= 1'b0;
    end else if (advance) begin
      b2_vld_q <= q_pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      b2_ctl_q    <= q_ctl_i;
      b2_bucket_q <= q_bucket_i;
    end
  end

  assign rb_addr    = q_ctl_i.sel[BIDX_W-1:0];
  assign hist_wr    = fire && (b2_ctl_q.act == ACT_REQ_END);
  assign hist_cur   = byp_a_q ? byp_data_q : (rda_vld_q ? rda_q : '0);
  assign hist_sel   = byp_b_q ? byp_data_q : (rdb_vld_q ? rdb_q : '0);
  assign hist_wdata = hist_cur + 1'b1;

  // two read ports, one write port; same-edge write is forwarded
  always_ff @(posedge clk_i) begin
    if (hist_wr) begin
      hist_mem[b2_bucket_q] <= hist_wdata;
    end
    if (q_pop_o) begin
      rda_q      <= hist_mem[q_bucket_i];
      rda_vld_q  <= hist_vld_q[q_bucket_i];
      rdb_q      <= hist_mem[rb_addr];
      rdb_vld_q  <= hist_vld_q[rb_addr];
      byp_a_q    <= hist_wr && (b2_bucket_q == q_bucket_i);
      byp_b_q    <= hist_wr && (b2_bucket_q == rb_addr);
      byp_data_q <= hist_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_vld_q <= '0;
    end else if (hist_wr) begin
      hist_vld_q[b2_bucket_q] <= 1'b1;
    end
  end

  assign period[0] = periods_i.minute;
  assign period[1] = periods_i.hour;
  assign period[2] = periods_i.day;

  always_comb begin
    for (int r = 0; r < NUM_ROLLING; r++) begin
      tick_nxt[r] = ticks_q[r] + 1'b1;
    end
  end

  always_comb begin
    tot_d       = tot_q;
    suc_d       = suc_q;
    pk_d        = pk_q;
    btot_d      = btot_q;
    bsuc_d      = bsuc_q;
    bpk_d       = bpk_q;
    in_flight_d = in_flight_q;
    conns_d     = conns_q;
    ticks_d     = ticks_q;
    roll        = '0;
    if (fire) begin
      unique case (b2_ctl_q.act)
        ACT_REQ_BEGIN: in_flight_d = in_flight_q + 1'b1;
        ACT_REQ_END: begin
          for (int w = 0; w < NUM_WINDOWS; w++) begin
            tot_d[w] = tot_q[w] + 1'b1;
            suc_d[w] = suc_q[w] + CW'(b2_ctl_q.success);
            pk_d[w]  = (in_flight_q > pk_q[w]) ? in_flight_q : pk_q[w];
          end
          in_flight_d = in_flight_q - 1'b1;
        end
        ACT_SEC_TICK: begin
          roll[0] = 1'b1;
          for (int r = 0; r < NUM_ROLLING; r++) begin
            if (tick_nxt[r] >= period[r]) begin
              ticks_d[r]  = '0;
              roll[r + 1] = 1'b1;
            end else begin
              ticks_d[r] = tick_nxt[r];
            end
          end
        end
        ACT_CONN_OPEN:  conns_d = conns_q + 1'b1;
        ACT_CONN_CLOSE: conns_d = conns_q - 1'b1;
        default: ;
      endcase
    end
    for (int w = 0; w < NUM_WINDOWS; w++) begin
      if (roll[w]) begin
        btot_d[w] = tot_q[w];
        bsuc_d[w] = suc_q[w];
        bpk_d[w]  = pk_q[w];
        tot_d[w]  = '0;
        suc_d[w]  = '0;
        pk_d[w]   = in_flight_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < NUM_WINDOWS; w++) begin
        tot_q[w]  <= '0;
        suc_q[w]  <= '0;
        pk_q[w]   <= '0;
        btot_q[w] <= '0;
        bsuc_q[w] <= '0;
        bpk_q[w]  <= '0;
      end
      for (int r = 0; r < NUM_ROLLING; r++) begin
        ticks_q[r] <= '0;
      end
      in_flight_q <= '0;
      conns_q     <= '0;
    end else begin
      tot_q       <= tot_d;
      suc_q       <= suc_d;
      pk_q        <= pk_d;
      btot_q      <= btot_d;
      bsuc_q      <= bsuc_d;
      bpk_q       <= bpk_d;
      ticks_q     <= ticks_d;
      in_flight_q <= in_flight_d;
      conns_q     <= conns_d;
    end
  end

  // read selection: buckets, window entries, connections, in-flight
  assign sel_x = XS'(b2_ctl_q.sel);

  always_comb begin
    win_hit  = 1'b0;
    win_live = '0;
    win_bak  = '0;
    for (int w = 0; w < NUM_WINDOWS; w++) begin
      if (sel_x == XS'(NB + NUM_KINDS * w)) begin
        win_hit  = 1'b1;
        win_live = tot_q[w];
        win_bak  = btot_q[w];
      end
      if (sel_x == XS'(NB + NUM_KINDS * w + 1)) begin
        win_hit  = 1'b1;
        win_live = suc_q[w];
        win_bak  = bsuc_q[w];
      end
      if (sel_x == XS'(NB + NUM_KINDS * w + 2)) begin
        win_hit  = 1'b1;
        win_live = pk_q[w];
        win_bak  = bpk_q[w];
      end
    end
  end

  always_comb begin
    priority if (sel_x < XS'(NB)) begin
      rd_val = hist_sel;
    end else if (win_hit) begin
      rd_val = (win_live > win_bak) ? win_live : win_bak;
    end else if (sel_x == XS'(NB + NUM_KINDS * NUM_WINDOWS)) begin
      rd_val = conns_q;
    end else if (sel_x == XS'(NB + NUM_KINDS * NUM_WINDOWS + 1)) begin
      rd_val = in_flight_q;
    end else begin
      rd_val = '0;
    end
  end

  assign rd_ext     = EXT_W'(rd_val);
  assign out_data_o = rd_ext[DATA_W-1:0];
  assign out_push_o = fire && (b2_ctl_q.act == ACT_READ);

endmodule

>>> hdl/request_latency_metrics_unit.sv
// ----------------------------------------------------------------------------
// request_latency_metrics_unit
// request latency histogram with windowed total, success and peak counters
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                     word
// --------  ---------  ----------------------------  ---------------------------------
// event     in         push / full                   action, latency, success, select
// result    out        pop / empty                   read value (reads only)
// config    in         psel, penable, pwrite, pready period registers (apb)
//
// one event word is taken every cycle while full is low; the back end retires one
//   event a cycle unless stalled; reads pass the back-end stage into the result queue
// reset zeroes every counter and loads periods of 60, 3600 and 86400 ticks;
//   histogram entries carry valid bits, so no clearing pass follows reset
// once untaken results fill the result queue, the back end stalls on the next read
//   and holds the words behind it; the event queue fills and full rises
//
`include "request_latency_metrics_unit_defines.svh"

module request_latency_metrics_unit import rlm_pkg::*; #(
  parameter int unsigned BUCKETS_PER_TIER = BUCKETS_PER_TIER_DEF,
  parameter int unsigned COUNTER_BITS     = COUNTER_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // event queue side
  input  logic              push,
  output logic              full,
  input  logic [ACT_W-1:0]  action_i,
  input  logic [LAT_W-1:0]  latency_ms_i,
  input  logic              success_flag_i,
  input  logic [SEL_W-1:0]  read_select_i,
  // result queue side
  output logic              empty,
  input  logic              pop,
  output logic [DATA_W-1:0] read_value_o,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int unsigned BIDX_W = $clog2(3 * BUCKETS_PER_TIER);
  localparam int unsigned CMD_W  = $bits(item_ctl_t) + BIDX_W;

  // period registers
  periods_t   periods_q;
  logic       cfg_wr;
  logic [1:0] cfg_idx;

  // front end to command queue
  logic              front_vld;
  item_ctl_t         front_ctl;
  logic [BIDX_W-1:0] front_bucket;
  logic              fq_push;

  // command queue to back end
  logic [CMD_W-1:0]  fq_rdata;
  logic              fq_pop, fq_empty;
  item_ctl_t         q_ctl;
  logic [BIDX_W-1:0] q_bucket;

  // back end to result queue
  logic              oq_push, oq_full;
  logic [DATA_W-1:0] oq_wdata;

  // --------------------------------------------------------------------------
  // configuration: three period registers, word aligned, always ready
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      periods_q.minute <= MINUTE_PERIOD_RST;
      periods_q.hour   <= HOUR_PERIOD_RST;
      periods_q.day    <= DAY_PERIOD_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MINUTE: periods_q.minute <= pwdata[PERIOD_W-1:0];
        REG_HOUR:   periods_q.hour   <= pwdata[PERIOD_W-1:0];
        REG_DAY:    periods_q.day    <= pwdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // register read back; the unused slot reads zero
  always_comb begin
    unique case (cfg_idx)
      REG_MINUTE: prdata = DATA_W'(periods_q.minute);
      REG_HOUR:   prdata = DATA_W'(periods_q.hour);
      REG_DAY:    prdata = DATA_W'(periods_q.day);
      default:    prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // front end: decode the event and pick the latency bucket up front,
  // unused event codes are taken and dropped here
  // --------------------------------------------------------------------------
  rlm_front #(
    .BUCKETS_PER_TIER (BUCKETS_PER_TIER)
  ) u_front (
    .action_i       (action_i),
    .latency_ms_i   (latency_ms_i),
    .success_flag_i (success_flag_i),
    .read_select_i  (read_select_i),
    .vld_o          (front_vld),
    .ctl_o          (front_ctl),
    .bucket_o       (front_bucket)
  );

  assign fq_push = push && !full && front_vld;

  // short command queue decouples acceptance from the counter update
  rlm_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_FIFO_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .wdata_i ({front_ctl, front_bucket}),
    .pop_i   (fq_pop),
    .rdata_o (fq_rdata),
    .full_o  (full),
    .empty_o (fq_empty)
  );

  assign {q_ctl, q_bucket} = fq_rdata;

  // --------------------------------------------------------------------------
  // back end: histogram memory read at pop, updated in the following cycle, with
  // forwarding so back-to-back ends into one bucket count correctly
  // --------------------------------------------------------------------------
  rlm_back #(
    .BUCKETS_PER_TIER (BUCKETS_PER_TIER),
    .COUNTER_BITS     (COUNTER_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .periods_i  (periods_q),
    .q_empty_i  (fq_empty),
    .q_ctl_i    (q_ctl),
    .q_bucket_i (q_bucket),
    .q_pop_o    (fq_pop),
    .out_full_i (oq_full),
    .out_push_o (oq_push),
    .out_data_o (oq_wdata)
  );

  // result queue, the skid between the back end and the consumer
  rlm_fifo #(
    .WIDTH (DATA_W),
    .DEPTH (OUT_FIFO_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (oq_push),
    .wdata_i (oq_wdata),
    .pop_i   (pop),
    .rdata_o (read_value_o),
    .full_o  (oq_full),
    .empty_o (empty)
  );

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // a decoded event that was taken is waiting in the command queue next cycle
  `RLM_ASSERT_NEXT(a_cmd_lands, clk_i, rst_ni, fq_push, !fq_empty)
  // the back end never pops an empty command queue
  `RLM_ASSERT_IMPL(a_pop_not_empty, clk_i, rst_ni, fq_pop, !fq_empty)
  // a minute period write lands in its register
  `RLM_ASSERT_NEXT(a_cfg_minute, clk_i, rst_ni, cfg_wr && (cfg_idx == REG_MINUTE), periods_q.minute == $past(pwdata[PERIOD_W-1:0]))

endmodule

>>> tb/sv/request_latency_metrics_unit_tb.sv
// ----------------------------------------------------------------------------
// request_latency_metrics_unit_tb
// self-checking bench for the latency histogram and windowed counters: a
// short table of hand-picked event words, then random event streams under
// several rollover periods; every read word is checked against a pinned value
// or a local mirror of the counters
// ----------------------------------------------------------------------------
module request_latency_metrics_unit_tb import rlm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // geometry of the default build
  localparam int unsigned B          = BUCKETS_PER_TIER_DEF;
  localparam int unsigned NBKT       = NUM_ROLLING * B;
  localparam int unsigned SEL_WIN    = NBKT;
  localparam logic [SEL_W-1:0] SEL_CONN   = SEL_W'(NBKT + NUM_KINDS * NUM_WINDOWS);
  localparam logic [SEL_W-1:0] SEL_FLIGHT = SEL_W'(NBKT + NUM_KINDS * NUM_WINDOWS + 1);
  localparam logic [SEL_W-1:0] SEL_TOP    = '1;

  // window order and the three values kept per window
  localparam int unsigned WIN_SECOND = 0;
  localparam int unsigned WIN_MINUTE = 1;
  localparam int unsigned WIN_ALL    = 4;
  localparam int unsigned KIND_TOTAL = 0;
  localparam int unsigned KIND_OK    = 1;
  localparam int unsigned KIND_PEAK  = 2;

  // action codes the block leaves unused
  localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES   = 120;
  localparam int unsigned DIRECTED_ROWS = 25;

  typedef logic [DATA_W-1:0] count_t;

  // one event word, plus an optional hand-typed read value
  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic [LAT_W-1:0] ms;
    logic             ok;
    logic [SEL_W-1:0] sel;
    logic             pinned;
    count_t           pinned_value;
  } stim_row_t;

  typedef struct packed {
    logic [SEL_W-1:0] sel;
    count_t           value;
  } due_read_t;

  // clock, reset and block inputs, all known from time zero
  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              push           = 1'b0;
  logic              full;
  logic [ACT_W-1:0]  action_i       = '0;
  logic [LAT_W-1:0]  latency_ms_i   = '0;
  logic              success_flag_i = 1'b0;
  logic [SEL_W-1:0]  read_select_i  = '0;
  logic              empty;
  logic              pop            = 1'b0;
  logic [DATA_W-1:0] read_value_o;
  logic              psel           = 1'b0;
  logic              penable        = 1'b0;
  logic              pwrite         = 1'b0;
  logic [ADDR_W-1:0] paddr          = '0;
  logic [DATA_W-1:0] pwdata         = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // mirror of the block's counters
  count_t              hist [NBKT]               = '{default: '0};
  count_t              live_total [NUM_WINDOWS]  = '{default: '0};
  count_t              live_ok [NUM_WINDOWS]     = '{default: '0};
  count_t              live_peak [NUM_WINDOWS]   = '{default: '0};
  count_t              saved_total [NUM_WINDOWS] = '{default: '0};
  count_t              saved_ok [NUM_WINDOWS]    = '{default: '0};
  count_t              saved_peak [NUM_WINDOWS]  = '{default: '0};
  count_t              flight                    = '0;
  count_t              conns                     = '0;
  logic [PERIOD_W-1:0] tick_count [NUM_ROLLING]  = '{default: '0};
  logic [PERIOD_W-1:0] period_set [NUM_ROLLING]  =
    '{MINUTE_PERIOD_RST, HOUR_PERIOD_RST, DAY_PERIOD_RST};

  // read words still owed by the block, oldest first
  due_read_t read_values_due [$];

  int errors        = 0;
  bit steady        = 1'b0;  // no idling on either side while set
  int holds_asked   = 0;
  int holds_served  = 0;

  request_latency_metrics_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .action_i      (action_i),
    .latency_ms_i  (latency_ms_i),
    .success_flag_i(success_flag_i),
    .read_select_i (read_select_i),
    .empty         (empty),
    .pop           (pop),
    .read_value_o  (read_value_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // 8 ns period
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [SEL_W-1:0] window_sel(int unsigned w, int unsigned kind);
    return SEL_W'(SEL_WIN + NUM_KINDS * w + kind);
  endfunction

  // directed words: fresh counters, tier edges, saturation, wrap below zero,
  // unused actions and selectors, then reads of what those left behind
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // everything reads zero straight out of reset
    '{ACT_READ,       32'd0,           1'b0, 6'd0,       1'b1, 32'd0},
    '{ACT_READ,       32'd0,           1'b0, SEL_FLIGHT, 1'b1, 32'd0},
    '{ACT_READ,       32'd0,           1'b0, SEL_CONN,   1'b1, 32'd0},
    '{ACT_READ,       32'hFFFF_FFFF,   1'b1, SEL_TOP,    1'b1, 32'd0},
    '{ACT_REQ_BEGIN,  32'd0,           1'b0, 6'd0,       1'b0, 32'd0},
    // low edge and top of the 10 ms tier
    '{ACT_REQ_END,    32'd0,           1'b1, 6'd0,       1'b0, 32'd0},
    // this end has no begin, in-flight wraps below zero
    '{ACT_REQ_END,    32'd99,          1'b0, 6'd0,       1'b0, 32'd0},
    // 100 ms tier edges
    '{ACT_REQ_END,    32'd100,         1'b1, 6'd0,       1'b0, 32'd0},
    '{ACT_REQ_END,    32'd999,         1'b0, 6'd0,       1'b0, 32'd0},
    // 1 s tier, then saturation of its last bucket
    '{ACT_REQ_END,    32'd1000,        1'b1, 6'd0,       1'b0, 32'd0},
    '{ACT_REQ_END,    32'd9999,        1'b1, 6'd0,       1'b0, 32'd0},
    '{ACT_REQ_END,    32'hFFFF_FFFF,   1'b1, 6'd0,       1'b0, 32'd0},
    // close with nothing open wraps the connection count
    '{ACT_CONN_CLOSE, 32'd0,           1'b0, 6'd0,       1'b0, 32'd0},
    '{ACT_CONN_OPEN,  32'd0,           1'b0, 6'd0,       1'b0, 32'd0},
    '{ACT_SEC_TICK,   32'd0,           1'b0, 6'd0,       1'b0, 32'd0},
    // unused codes must leave all counters alone
    '{ACT_SPARE_LO,   32'd0,           1'b0, 6'd0,       1'b0, 32'd0},
    '{ACT_SPARE_HI,   32'hFFFF_FFFF,   1'b1, SEL_TOP,    1'b0, 32'd0},
    '{ACT_READ,       32'd0,           1'b0, 6'd29,      1'b0, 32'd0},
    '{ACT_READ,       32'd0,           1'b0, window_sel(WIN_SECOND, KIND_TOTAL), 1'b0, 32'd0},
    '{ACT_READ,       32'd0,           1'b0, window_sel(WIN_SECOND, KIND_PEAK),  1'b0, 32'd0},
    '{ACT_READ,       32'd0,           1'b0, window_sel(WIN_ALL, KIND_TOTAL),    1'b0, 32'd0},
    '{ACT_READ,       32'd0,           1'b0, window_sel(WIN_ALL, KIND_PEAK),     1'b0, 32'd0},
    '{ACT_READ,       32'd0,           1'b0, window_sel(WIN_MINUTE, KIND_OK),    1'b0, 32'd0},
    '{ACT_READ,       32'd0,           1'b0, SEL_FLIGHT, 1'b0, 32'd0},
    '{ACT_READ,       32'd0,           1'b0, 6'd11,      1'b0, 32'd0}
  };

  function automatic count_t larger(count_t a, count_t b);
    return (a > b) ? a : b;
  endfunction

  // histogram slot of one latency: 10 ms, 100 ms, then saturating 1 s tier
  function automatic int unsigned bucket_for(logic [LAT_W-1:0] ms);
    if (ms < SHORT_MS * B) return ms / SHORT_MS;
    if (ms < MID_MS * B) return B + ms / MID_MS;
    if (ms / LONG_MS > B - 1) return NBKT - 1;
    return 2 * B + ms / LONG_MS;
  endfunction

  // back up a window and start it over; peak restarts at in-flight
  function automatic void roll_window(int unsigned w);
    saved_total[w] = live_total[w];
    saved_ok[w]    = live_ok[w];
    saved_peak[w]  = live_peak[w];
    live_total[w]  = '0;
    live_ok[w]     = '0;
    live_peak[w]   = flight;
  endfunction

  // apply one accepted event word to the mirror; reads give a value
  function automatic void track_event(input stim_row_t row, output bit gives_value,
                                      output count_t value);
    int unsigned         slot;
    int unsigned         w;
    logic [PERIOD_W-1:0] nxt;
    gives_value = 1'b0;
    value       = '0;
    case (row.act)
      ACT_REQ_BEGIN: flight++;
      ACT_REQ_END: begin
        hist[bucket_for(row.ms)]++;
        for (int unsigned i = 0; i < NUM_WINDOWS; i++) begin
          live_total[i]++;
          live_ok[i]  += row.ok;
          // peak sees the count before this end lowers it
          live_peak[i] = larger(live_peak[i], flight);
        end
        flight--;
      end
      ACT_SEC_TICK: begin
        roll_window(WIN_SECOND);
        for (int unsigned r = 0; r < NUM_ROLLING; r++) begin
          nxt = tick_count[r] + 1'b1;
          if (nxt >= period_set[r]) begin
            tick_count[r] = '0;
            roll_window(r + 1);
          end else begin
            tick_count[r] = nxt;
          end
        end
      end
      ACT_CONN_OPEN:  conns++;
      ACT_CONN_CLOSE: conns--;
      ACT_READ: begin
        gives_value = 1'b1;
        if (row.sel < NBKT) begin
          value = hist[row.sel];
        end else if (row.sel < SEL_CONN) begin
          slot = row.sel - SEL_WIN;
          w    = slot / NUM_KINDS;
          case (slot % NUM_KINDS)
            KIND_TOTAL: value = larger(live_total[w], saved_total[w]);
            KIND_OK:    value = larger(live_ok[w], saved_ok[w]);
            default:    value = larger(live_peak[w], saved_peak[w]);
          endcase
        end else if (row.sel == SEL_CONN) begin
          value = conns;
        end else if (row.sel == SEL_FLIGHT) begin
          value = flight;
        end
      end
      default: ;
    endcase
  endfunction

  // random word; ends and closes mostly follow a matching begin or open
  function automatic stim_row_t random_event(int unsigned read_pct);
    stim_row_t   row;
    int unsigned pick;
    case ($urandom_range(0, 3))
      0:       row.ms = $urandom_range(0, SHORT_MS * B - 1);
      1:       row.ms = $urandom_range(SHORT_MS * B, MID_MS * B - 1);
      2:       row.ms = $urandom_range(MID_MS * B, LONG_MS * (B + 2));
      default: row.ms = $urandom;
    endcase
    row.ok           = $urandom_range(0, 1);
    row.sel          = ($urandom_range(0, 9) == 0) ? SEL_W'($urandom_range(SEL_FLIGHT + 1, SEL_TOP))
                                                   : SEL_W'($urandom_range(0, SEL_FLIGHT));
    row.pinned       = 1'b0;
    row.pinned_value = '0;
    pick = $urandom_range(0, 99);
    if (pick < read_pct) begin
      row.act = ACT_READ;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        row.act = ACT_REQ_BEGIN;
      end else if (pick < 60) begin
        row.act = (flight != 0 || $urandom_range(0, 9) == 0) ? ACT_REQ_END : ACT_REQ_BEGIN;
      end else if (pick < 78) begin
        row.act = ACT_SEC_TICK;
      end else if (pick < 87) begin
        row.act = ACT_CONN_OPEN;
      end else if (pick < 95) begin
        row.act = (conns != 0 || $urandom_range(0, 9) == 0) ? ACT_CONN_CLOSE : ACT_CONN_OPEN;
      end else begin
        row.act = $urandom_range(0, 1) ? ACT_SPARE_HI : ACT_SPARE_LO;
      end
    end
    return row;
  endfunction

  // offer one word until taken, log its read value if any, then maybe idle
  task automatic send_event(input stim_row_t row);
    bit        gives_value;
    count_t    predicted;
    due_read_t owed;
    int        gap;
    push           <= 1'b1;
    action_i       <= row.act;
    latency_ms_i   <= row.ms;
    success_flag_i <= row.ok;
    read_select_i  <= row.sel;
    do @(posedge clk_i); while (full);
    track_event(row, gives_value, predicted);
    if (gives_value) begin
      owed.sel        = row.sel;
      owed.value      = row.pinned ? row.pinned_value : predicted;
      read_values_due = {read_values_due, owed};
    end
    gap = 0;
    if (!steady)
      while ($urandom_range(0, 99) < 30) gap++;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic run_random(input int unsigned items, input int unsigned read_pct);
    int unsigned counted;
    stim_row_t   row;
    counted = 0;
    // ignored action codes do not count toward the total
    while (counted < items) begin
      row = random_event(read_pct);
      send_event(row);
      if (row.act <= ACT_READ) counted++;
    end
  endtask

  // stop offering and wait until every owed read word has come back
  task automatic park_until_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (read_values_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic read_period(input logic [1:0] idx, input logic [PERIOD_W-1:0] want);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= ADDR_W'({idx, 2'b00});
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== DATA_W'(want)) begin
      $display("%0t: period register %0d readback: expected %h, got %h",
               $time, idx, DATA_W'(want), prdata);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_period(input logic [1:0] idx, input logic [PERIOD_W-1:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= DATA_W'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    period_set[idx] = val;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // new periods only once the block has gone quiet; each write is read back
  task automatic set_periods(input logic [PERIOD_W-1:0] minute,
                             input logic [PERIOD_W-1:0] hour,
                             input logic [PERIOD_W-1:0] day);
    park_until_drained();
    // non-read words may still be in the event queue
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_period(REG_MINUTE, minute);
    read_period(REG_MINUTE, minute);
    write_period(REG_HOUR, hour);
    read_period(REG_HOUR, hour);
    write_period(REG_DAY, day);
    read_period(REG_DAY, day);
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin : result_taker
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (holds_asked != holds_served) begin
        holds_served = holds_asked;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= steady || ($urandom_range(0, 99) >= 30);
      end
    end
  end

  // every taken result word must match the oldest owed read
  always @(posedge clk_i) begin : result_check
    due_read_t want;
    if (rst_ni && pop && !empty) begin
      if (read_values_due.size() == 0) begin
        $display("%0t: unexpected result word: expected none, got %h", $time, read_value_o);
        errors++;
      end else begin
        want = read_values_due.pop_front();
        if (read_value_o !== want.value) begin
          $display("%0t: read of select %0d: expected %h, got %h",
                   $time, want.sel, want.value, read_value_o);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // periods come out of reset at their defaults
    read_period(REG_MINUTE, MINUTE_PERIOD_RST);
    read_period(REG_HOUR, HOUR_PERIOD_RST);
    read_period(REG_DAY, DAY_PERIOD_RST);

    foreach (directed_rows[i]) send_event(directed_rows[i]);

    run_random(50, 28);

    // short periods: the minute window rolls on every tick, hour and day windows often
    set_periods(20'd1, 20'd2, 20'd3);
    run_random(70, 28);

    // longest day period; a stretch with no idling on either side
    set_periods(20'd5, 20'd7, 20'hF_FFFF);
    steady = 1'b1;
    run_random(70, 28);
    steady = 1'b0;

    // result side holds off while read-heavy words keep coming, so the
    // block fills up and raises full
    holds_asked++;
    run_random(40, 70);

    // sender sits out until every owed read has come back
    park_until_drained();
    run_random(50, 28);

    // day period drops below its running tick count, rolls on next tick
    set_periods(20'hF_FFFF, 20'd1, 20'd4);
    run_random(70, 28);

    set_periods(PERIOD_W'($urandom_range(1, 20)), PERIOD_W'($urandom_range(1, 20)),
                PERIOD_W'($urandom_range(1, 20)));
    run_random(50, 28);

    park_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // generous cap, far past the slowest correct run
  initial begin : watchdog
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/rlm_pkg.sv
hdl/rlm_fifo.sv
hdl/rlm_front.sv
hdl/rlm_back.sv
hdl/request_latency_metrics_unit.sv
tb/sv/request_latency_metrics_unit_tb.sv
